>>> sv/closed_polyline_eval_and_perimeter_macros.svh
// Assertion macros for the polyline block
`ifndef CLOSED_POLYLINE_EVAL_AND_PERIMETER_MACROS_SVH
`define CLOSED_POLYLINE_EVAL_AND_PERIMETER_MACROS_SVH
// a implies b in the same cycle
`define CPL_ASSERT_IMP(label, a, b) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (b)) \
		else $error("label failed");
// a implies b in the following cycle
`define CPL_ASSERT_NEXT(label, a, b) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (b)) \
		else $error("label failed");
`endif

>>> sv/cpl_pkg.sv
`default_nettype none
package cpl_pkg;
	localparam int MaxPoints = 256;
	localparam int IdxW = $clog2(MaxPoints);
	localparam logic [1:0] CMD_WRITE = 2'd0;
	localparam logic [1:0] CMD_EVAL = 2'd1;
	localparam logic [1:0] CMD_PERIM = 2'd2;

	// controller to datapath
	typedef struct packed {
		logic load;       // capture the input transaction
		logic wr;         // write vertex
		logic div_step;   // one modulo step
		logic rd;         // issue a read at rd_addr
		logic [1:0] rd_sel; // 0 first vertex, 1 second vertex
		logic blend;      // multiply stage
		logic blend2;     // rounding stage
		logic sq;         // squares of the edge
		logic rt_init;    // sum of squares, start a root
		logic rt_step;    // one root step
		logic acc;        // add root to sum
		logic perim_clr;  // clear sum
		logic out_pt;     // load point result
		logic out_pr;     // load perimeter result
	} cmd_t;

	typedef struct packed {
		logic div_done;
		logic rt_done;
	} stat_t;
endpackage
`default_nettype wire

>>> sv/closed_polyline_eval_and_perimeter.sv
// Closed polyline store with point evaluation and perimeter.
// Input channel s_axis_*: tdata carries command, vertex_index, vertex_x,
// vertex_y and curve_param. A write gives no result.
// Evaluate: 16 modulo steps in a restoring divider, two memory reads, a
// multiply stage and a rounding stage; then the point is loaded into the
// output register and the block returns to idle for the next input.
// Perimeter: per vertex two reads, squares, a sum and 18 root steps of the
// iterative square root unit, then the root is added to the perimeter sum;
// after the last vertex the sum is loaded into the output register.
// One item is worked on at a time; the input is ready only when idle.
// The result sits in an output register until m_axis_tready takes it;
// a stalled receiver holds the block before the next result is loaded.
// Configuration (cfg_valid/cfg_ready/cfg_data) sets point_count, reset 1;
// cfg_ready is high only while the block is idle.
// Reset clears control state; vertex memory is undefined until written.
`default_nettype none
`include "closed_polyline_eval_and_perimeter_macros.svh"
module closed_polyline_eval_and_perimeter (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic s_axis_tvalid,
	output logic s_axis_tready,
	// command[1:0], vertex_index[9:2], vertex_x[25:10], vertex_y[41:26],
	// curve_param[65:42], zero fill to 72
	input  wire logic [71:0] s_axis_tdata,
	output logic m_axis_tvalid,
	input  wire logic m_axis_tready,
	// point_x[15:0], point_y[31:16], perimeter[63:32]
	output logic [63:0] m_axis_tdata,
	// result_kind
	output logic m_axis_tuser,
	input  wire logic cfg_valid,
	output logic cfg_ready,
	input  wire logic [8:0] cfg_data
);
	import cpl_pkg::*;
	logic [8:0] pc_q;
	logic [IdxW:0] n;
	cmd_t c;
	stat_t st;
	logic [IdxW-1:0] rd_addr, i0;
	logic busy, in_fire, out_free;
	logic signed [15:0] ox, oy;
	logic [31:0] op;
	assign cfg_ready = !busy;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) pc_q <= 9'd1;
		else if (cfg_valid && cfg_ready) pc_q <= cfg_data;
	end
	assign n = (pc_q == 0) ? (IdxW+1)'(1) :
		((32'(pc_q) > MaxPoints) ? (IdxW+1)'(MaxPoints) : (IdxW+1)'(pc_q));
	assign s_axis_tready = !busy;
	assign in_fire = s_axis_tvalid && s_axis_tready;
	assign out_free = !m_axis_tvalid || m_axis_tready;
	cpl_ctrl u_ctrl (.clk, .arst_n, .in_fire, .in_cmd(s_axis_tdata[1:0]), .out_free,
		.n, .st, .i0, .c, .rd_addr, .busy);
	cpl_dp u_dp (.clk, .arst_n, .c, .rd_addr, .n, .in_index(s_axis_tdata[9:2]),
		.in_x(s_axis_tdata[25:10]), .in_y(s_axis_tdata[41:26]),
		.in_t(s_axis_tdata[65:42]), .st, .i0,
		.out_valid(m_axis_tvalid), .out_taken(m_axis_tready), .out_kind(m_axis_tuser),
		.out_x(ox), .out_y(oy), .out_perim(op));
	assign m_axis_tdata = {op, oy, ox};
	`CPL_ASSERT_IMP(a_no_accept_busy, busy, !s_axis_tready)
	`CPL_ASSERT_NEXT(a_hold_out, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
	`CPL_ASSERT_IMP(a_one_load, c.out_pt, !c.out_pr)
endmodule
`default_nettype wire

>>> sv/cpl_ctrl.sv
`default_nettype none
module cpl_ctrl (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_fire,
	input  wire logic [1:0] in_cmd,
	input  wire logic out_free,
	input  wire logic [cpl_pkg::IdxW:0] n,
	input  wire cpl_pkg::stat_t st,
	input  wire logic [cpl_pkg::IdxW-1:0] i0,
	output cpl_pkg::cmd_t c,
	output logic [cpl_pkg::IdxW-1:0] rd_addr,
	output logic busy
);
	import cpl_pkg::*;
	localparam logic [3:0] S_IDLE = 4'd0, S_DIV = 4'd1, S_RA = 4'd2, S_RB = 4'd3,
		S_WA = 4'd4, S_MUL = 4'd5, S_RND = 4'd6, S_OUTP = 4'd7, S_PRA = 4'd8,
		S_PRB = 4'd9, S_PW = 4'd10, S_SQ = 4'd11, S_SS = 4'd12, S_RT = 4'd13,
		S_ACC = 4'd14, S_OUTR = 4'd15;
	logic [3:0] state_q;
	logic [IdxW:0] k_q;
	always_comb begin
		c = '0;
		rd_addr = '0;
		busy = (state_q != S_IDLE);
		case (state_q)
			S_IDLE: c.load = in_fire;
			S_DIV: c.div_step = !st.div_done;
			S_RA: begin c.rd = 1'b1; c.rd_sel = 2'd0; rd_addr = i0; end
			S_RB: begin
				c.rd = 1'b1; c.rd_sel = 2'd1;
				rd_addr = i0 + 1'b1;
				if ({1'b0, i0} + 1'b1 >= n) rd_addr = '0;
			end
			S_MUL: c.blend = 1'b1;
			S_RND: c.blend2 = 1'b1;
			S_OUTP: c.out_pt = out_free;
			S_PRA: begin
				c.rd = 1'b1; c.rd_sel = 2'd0;
				rd_addr = (k_q == '0) ? IdxW'(n - 1'b1) : IdxW'(k_q - 1'b1);
			end
			S_PRB: begin c.rd = 1'b1; c.rd_sel = 2'd1; rd_addr = IdxW'(k_q); end
			S_SQ: c.sq = 1'b1;
			S_SS: c.rt_init = 1'b1;
			S_RT: c.rt_step = !st.rt_done;
			S_ACC: c.acc = 1'b1;
			S_OUTR: c.out_pr = out_free;
			default: ;
		endcase
		if (state_q == S_IDLE && in_fire && in_cmd == CMD_WRITE) c.wr = 1'b1;
		if (state_q == S_IDLE && in_fire && in_cmd == CMD_PERIM) c.perim_clr = 1'b1;
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			k_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: if (in_fire) begin
					k_q <= '0;
					if (in_cmd == CMD_EVAL) state_q <= S_DIV;
					else if (in_cmd == CMD_PERIM) state_q <= S_PRA;
				end
				S_DIV: if (st.div_done) state_q <= S_RA;
				S_RA: state_q <= S_RB;
				S_RB: state_q <= S_WA;
				S_WA: state_q <= S_MUL;
				S_MUL: state_q <= S_RND;
				S_RND: state_q <= S_OUTP;
				S_OUTP: if (out_free) state_q <= S_IDLE;
				S_PRA: state_q <= S_PRB;
				S_PRB: state_q <= S_PW;
				S_PW: state_q <= S_SQ;
				S_SQ: state_q <= S_SS;
				S_SS: state_q <= S_RT;
				S_RT: if (st.rt_done) state_q <= S_ACC;
				S_ACC: begin
					k_q <= k_q + 1'b1;
					state_q <= (k_q + 1'b1 >= n) ? S_OUTR : S_PRA;
				end
				S_OUTR: if (out_free) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

>>> sv/cpl_dp.sv
`default_nettype none
module cpl_dp (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire cpl_pkg::cmd_t c,
	input  wire logic [cpl_pkg::IdxW-1:0] rd_addr,
	input  wire logic [cpl_pkg::IdxW:0] n,
	input  wire logic [7:0] in_index,
	input  wire logic signed [15:0] in_x,
	input  wire logic signed [15:0] in_y,
	input  wire logic signed [23:0] in_t,
	output cpl_pkg::stat_t st,
	output logic [cpl_pkg::IdxW-1:0] i0,
	output logic out_valid,
	input  wire logic out_taken,
	output logic out_kind,
	output logic signed [15:0] out_x,
	output logic signed [15:0] out_y,
	output logic [31:0] out_perim
);
	import cpl_pkg::*;
	logic signed [15:0] xmem [MaxPoints];
	logic signed [15:0] ymem [MaxPoints];
	logic signed [15:0] rx_q, ry_q, ax_q, ay_q, bx_q, by_q;
	logic [1:0] sel_q;
	logic rdv_q;
	// vertex memory, one write and one registered read port
	always_ff @(posedge clk) begin
		if (c.wr && ({24'd0, in_index} < 32'(MaxPoints))) begin
			xmem[IdxW'(in_index)] <= in_x;
			ymem[IdxW'(in_index)] <= in_y;
		end
		if (c.rd) begin
			rx_q <= xmem[rd_addr];
			ry_q <= ymem[rd_addr];
		end
		sel_q <= c.rd_sel;
		rdv_q <= c.rd;
		if (rdv_q) begin
			if (sel_q == 2'd0) begin ax_q <= rx_q; ay_q <= ry_q; end
			else begin bx_q <= rx_q; by_q <= ry_q; end
		end
	end
	// restoring modulo of the floored integer part, one bit a step
	logic [7:0] f_q;
	logic [15:0] mag_q;
	logic neg_q;
	logic [IdxW:0] rem_q;
	logic [4:0] dcnt_q;
	logic [IdxW+1:0] trial;
	logic [IdxW:0] remf;
	assign trial = {rem_q, mag_q[15]};
	always_comb begin
		remf = rem_q;
		if (neg_q && rem_q != 0) remf = n - rem_q;
	end
	assign i0 = IdxW'(remf);
	always_ff @(posedge clk) begin
		if (c.load) begin
			f_q <= in_t[7:0];
			neg_q <= in_t[23];
			mag_q <= in_t[23] ? 16'(-{in_t[23:8]}) : in_t[23:8];
			rem_q <= '0;
			dcnt_q <= '0;
		end else if (c.div_step) begin
			mag_q <= {mag_q[14:0], 1'b0};
			rem_q <= (trial >= {1'b0, n}) ? (IdxW+1)'(trial - n) : trial[IdxW:0];
			dcnt_q <= dcnt_q + 1'b1;
		end
	end
	// blend a*(256-f) + b*f, then round
	logic signed [25:0] mx_s1, my_s1;
	logic signed [15:0] px_q, py_q;
	logic signed [9:0] wa, wb;
	assign wa = 10'sd256 - $signed({2'b0, f_q});
	assign wb = $signed({2'b0, f_q});
	always_ff @(posedge clk) begin
		if (c.blend) begin
			mx_s1 <= 26'(ax_q * wa) + 26'(bx_q * wb);
			my_s1 <= 26'(ay_q * wa) + 26'(by_q * wb);
		end
		if (c.blend2) begin
			px_q <= 16'((mx_s1 + 26'sd128) >>> 8);
			py_q <= 16'((my_s1 + 26'sd128) >>> 8);
		end
	end
	// edge squares, sum, then a root with one result bit per step
	logic signed [16:0] dx, dy;
	logic [33:0] sqx_q, sqy_q;
	logic [34:0] v_q;
	logic [35:0] root_q;
	logic [35:0] bit_q;
	logic [32:0] sum_q;
	logic [35:0] rb;
	assign dx = 17'(bx_q) - 17'(ax_q);
	assign dy = 17'(by_q) - 17'(ay_q);
	assign rb = root_q + bit_q;
	always_ff @(posedge clk) begin
		if (c.sq) begin
			sqx_q <= 34'(dx * dx);
			sqy_q <= 34'(dy * dy);
		end
		if (c.rt_init) begin
			v_q <= 35'(sqx_q) + 35'(sqy_q);
			root_q <= '0;
			bit_q <= 36'd1 << 34;
		end else if (c.rt_step) begin
			if ({1'b0, v_q} >= rb) begin
				v_q <= 35'({1'b0, v_q} - rb);
				root_q <= (root_q >> 1) + bit_q;
			end else root_q <= root_q >> 1;
			bit_q <= bit_q >> 2;
		end
		if (c.perim_clr) sum_q <= '0;
		else if (c.acc) begin
			sum_q <= (sum_q + 33'(root_q) > 33'hFFFFFFFF) ? 33'hFFFFFFFF :
				sum_q + 33'(root_q);
		end
	end
	// status to the controller
	always_comb begin
		st.div_done = (dcnt_q == 5'd16);
		st.rt_done = (bit_q == '0);
	end
	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (c.out_pt || c.out_pr) out_valid <= 1'b1;
		else if (out_taken) out_valid <= 1'b0;
	end
	always_ff @(posedge clk) begin
		if (c.out_pt) begin
			out_kind <= 1'b0; out_x <= px_q; out_y <= py_q; out_perim <= '0;
		end else if (c.out_pr) begin
			out_kind <= 1'b1; out_x <= '0; out_y <= '0; out_perim <= sum_q[31:0];
		end
	end
endmodule
`default_nettype wire

>>> bench/closed_polyline_eval_and_perimeter_tb.sv
`default_nettype none
module closed_polyline_eval_and_perimeter_tb;
	import cpl_pkg::*;

	localparam logic [1:0] CmdUnused = 2'd3;

	typedef struct packed {
		logic        kind;
		logic [15:0] px;
		logic [15:0] py;
		logic [31:0] perim;
	} outcome_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [71:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [63:0] m_axis_tdata;
	logic m_axis_tuser;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [8:0] cfg_data = '0;

	// predictor state
	logic signed [15:0] vx [MaxPoints];
	logic signed [15:0] vy [MaxPoints];
	int unsigned n_pts = 1;
	outcome_t awaited[$];
	int errors = 0;
	int idle_pct = 0;
	int stall_pct = 0;
	int watchdog = 0;

	always #10 clk = ~clk;

	closed_polyline_eval_and_perimeter u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	function automatic logic signed [15:0] mix(logic signed [15:0] a,
			logic signed [15:0] b, int f);
		longint v;
		v = longint'(a) * (256 - f) + longint'(b) * f + 128;
		return 16'(v >>> 8);
	endfunction

	function automatic longint unsigned root_floor(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic outcome_t point_at(logic signed [23:0] t);
		outcome_t o;
		int f, ip, i, j;
		f = int'(t[7:0]);
		ip = int'(t) >>> 8;
		i = ip % int'(n_pts);
		if (i < 0) i += n_pts;
		j = (i + 1) % n_pts;
		o.kind = 1'b0;
		o.px = mix(vx[i], vx[j], f);
		o.py = mix(vy[i], vy[j], f);
		o.perim = '0;
		return o;
	endfunction

	function automatic outcome_t perimeter_now();
		outcome_t o;
		longint unsigned sum, dx, dy;
		int prev;
		sum = 0;
		prev = n_pts - 1;
		for (int k = 0; k < n_pts; k++) begin
			dx = longint'(vx[k]) - longint'(vx[prev]);
			dy = longint'(vy[k]) - longint'(vy[prev]);
			sum += root_floor(dx * dx + dy * dy);
			if (sum > 64'hFFFF_FFFF) sum = 64'hFFFF_FFFF;
			prev = k;
		end
		o = '0;
		o.kind = 1'b1;
		o.perim = sum[31:0];
		return o;
	endfunction

	// send one item and record what it should produce; valid stays high
	// for a following item and is dropped when the sender idles or drains
	task automatic send_item(logic [1:0] cmd, logic [7:0] idx, logic [15:0] x,
			logic [15:0] y, logic [23:0] t);
		if ($urandom_range(99) < idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
			while ($urandom_range(99) < idle_pct) @(negedge clk);
		end
		s_axis_tdata <= {6'b0, t, y, x, idx, cmd};
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		case (cmd)
			CMD_WRITE: begin
				vx[idx] = x;
				vy[idx] = y;
			end
			CMD_EVAL: awaited.push_back(point_at(t));
			CMD_PERIM: awaited.push_back(perimeter_now());
			default: ;
		endcase
		@(negedge clk);
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (awaited.size() != 0) @(negedge clk);
		repeat (40) @(negedge clk);
	endtask

	// register write while idle
	task automatic set_count(int unsigned n);
		drain();
		cfg_data <= 9'(n);
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		if (n == 0) n_pts = 1;
		else if (n > MaxPoints) n_pts = MaxPoints;
		else n_pts = n;
	endtask

	task automatic fill_vertices(int unsigned n, bit extreme);
		logic [15:0] x, y;
		for (int k = 0; k < n; k++) begin
			x = extreme ? ((k % 2) ? 16'h7FFF : 16'h8000) : 16'($urandom);
			y = extreme ? ((k % 2) ? 16'h8000 : 16'h7FFF) : 16'($urandom);
			send_item(CMD_WRITE, 8'(k), x, y, 24'($urandom));
		end
	endtask

	task automatic test_directed();
		set_count(1);
		send_item(CMD_WRITE, 8'd0, 16'h1234, 16'hFEDC, 24'h0);
		send_item(CMD_EVAL, 8'hFF, 16'hFFFF, 16'hFFFF, 24'h7FFFFF);
		send_item(CMD_PERIM, 8'h00, 16'h0, 16'h0, 24'h800000);
		send_item(CmdUnused, 8'hAA, 16'h5555, 16'hAAAA, 24'h555555);
		set_count(2);
		fill_vertices(2, 1'b1);
		send_item(CMD_EVAL, 8'h0, 16'h0, 16'h0, 24'h000080);
		send_item(CMD_EVAL, 8'h0, 16'h0, 16'h0, 24'h800000);
		send_item(CMD_EVAL, 8'h0, 16'h0, 16'h0, 24'hFFFFFF);
		send_item(CMD_EVAL, 8'h0, 16'h0, 16'h0, 24'h7FFFFF);
		send_item(CMD_PERIM, 8'h0, 16'h0, 16'h0, 24'h0);
		// largest perimeter over all slots at the extremes
		set_count(256);
		fill_vertices(256, 1'b1);
		send_item(CMD_PERIM, 8'h0, 16'h0, 16'h0, 24'h0);
		send_item(CMD_EVAL, 8'h0, 16'h0, 16'h0, 24'hFFFF7F);
		// out-of-range counts
		set_count(0);
		send_item(CMD_EVAL, 8'h0, 16'h0, 16'h0, 24'h123456);
		set_count(511);
		send_item(CMD_EVAL, 8'h0, 16'h0, 16'h0, 24'hABCDEF);
		send_item(CMD_PERIM, 8'h0, 16'h0, 16'h0, 24'h0);
	endtask

	task automatic test_random(int items);
		int unsigned n;
		logic [1:0] c;
		for (int k = 0; k < items; k++) begin
			if (k % 100 == 0) begin
				n = ($urandom_range(9) == 0) ? $urandom_range(256, 1) : $urandom_range(8, 1);
				set_count(n);
				fill_vertices(n, 1'b0);
			end
			c = 2'($urandom_range(19) < 15 ? CMD_EVAL :
				($urandom_range(3) == 0 ? CmdUnused :
				($urandom_range(1) ? CMD_PERIM : CMD_WRITE)));
			if (c == CMD_WRITE)
				send_item(c, 8'($urandom_range(n - 1)), 16'($urandom), 16'($urandom),
					24'($urandom));
			else
				send_item(c, 8'($urandom), 16'($urandom), 16'($urandom), 24'($urandom));
			if (k == 150) drain();
		end
	endtask

	// receiver stall
	always @(negedge clk)
		m_axis_tready <= ($urandom_range(99) >= stall_pct);

	// result checker
	always @(posedge clk) begin
		outcome_t got, exp_o;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = {m_axis_tuser, m_axis_tdata[15:0], m_axis_tdata[31:16],
				m_axis_tdata[63:32]};
			if (awaited.size() == 0) begin
				$display("%0t unexpected result exp none got %h", $time, got);
				errors++;
			end else begin
				exp_o = awaited.pop_front();
				if (got.kind !== exp_o.kind)
					$display("%0t kind exp %0d got %0d", $time, exp_o.kind, got.kind);
				if (got.px !== exp_o.px)
					$display("%0t point_x exp %h got %h", $time, exp_o.px, got.px);
				if (got.py !== exp_o.py)
					$display("%0t point_y exp %h got %h", $time, exp_o.py, got.py);
				if (got.perim !== exp_o.perim)
					$display("%0t perimeter exp %0d got %0d", $time, exp_o.perim, got.perim);
				if (got !== exp_o) errors++;
			end
		end
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(cfg_valid && cfg_ready))
			watchdog <= 0;
		else
			watchdog <= watchdog + 1;
		if (watchdog > 200000) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed();
		test_random(300);
		idle_pct = 79;
		test_random(250);
		idle_pct = 0;
		stall_pct = 79;
		test_random(250);
		idle_pct = 29;
		stall_pct = 29;
		test_random(300);
		drain();
		if (errors == 0 && awaited.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule
`default_nettype wire
